>>> rtl/hsv_fade_rgb_pwm_driver_unit_defines.svh
// ----------------------------------------------------------------------------
// HSV fade driver assertion macros
// Shared concurrent checks, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HSV_FADE_RGB_PWM_DRIVER_UNIT_DEFINES_SVH
`define HSV_FADE_RGB_PWM_DRIVER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HFRPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HFRPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hfrpd_pkg.sv
// ----------------------------------------------------------------------------
// HSV fade driver package
// Shared constants, command and register codes, and the configuration struct.
// ----------------------------------------------------------------------------
package hfrpd_pkg;

    localparam int CHANNEL_BITS_DEF = 16;
    localparam int DUTY_BITS_DEF    = 8;
    localparam int FIELD_BITS       = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int APB_ADDR_BITS    = 4;
    localparam int APB_DATA_BITS    = 32;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_SETTLE = 2'd0;
    localparam logic [1:0] REG_RATE   = 2'd1;
    localparam logic [1:0] REG_GAMMA  = 2'd2;

    localparam logic [FIELD_BITS-1:0] SETTLE_RESET = 16'd328;
    localparam logic [FIELD_BITS-1:0] RATE_RESET   = 16'd66;
    localparam logic                  GAMMA_RESET  = 1'b1;

    // Hue sectors of the six-sector conversion
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;

    typedef struct packed {
        logic [FIELD_BITS-1:0] settle_threshold;
        logic [FIELD_BITS-1:0] rate_per_ms;
        logic                  gamma_enable;
    } cfg_t;

endpackage

>>> rtl/hfrpd_front.sv
// ----------------------------------------------------------------------------
// HSV fade driver front end
// Accepts commands, classifies them and works out the saturated tick step.
// ----------------------------------------------------------------------------
module hfrpd_front
    import hfrpd_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic                      command,
    input  logic [FIELD_BITS-1:0]     hue,
    input  logic [FIELD_BITS-1:0]     saturation,
    input  logic [FIELD_BITS-1:0]     brightness,
    input  logic [FIELD_BITS-1:0]     elapsed_ms,
    output logic                      push,
    output logic [4*CHANNEL_BITS+1:0] entry,
    input  logic                      full
);

    localparam logic [31:0]           FullWide = 32'(1) << CHANNEL_BITS;
    localparam logic [CHANNEL_BITS:0] FullStep = {1'b1, {CHANNEL_BITS{1'b0}}};

    logic                    stage_valid_reg;
    logic                    kind_reg;
    logic [CHANNEL_BITS-1:0] hue_reg;
    logic [CHANNEL_BITS-1:0] sat_reg;
    logic [CHANNEL_BITS-1:0] val_reg;
    logic [31:0]             raw_reg;
    logic [CHANNEL_BITS:0]   step;
    logic                    take;

    assign cmd_stall = stage_valid_reg && full;
    assign take      = cmd_valid && !cmd_stall;
    assign push      = stage_valid_reg && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= command;
            hue_reg  <= CHANNEL_BITS'(hue);
            sat_reg  <= CHANNEL_BITS'(saturation);
            val_reg  <= CHANNEL_BITS'(brightness);
            raw_reg  <= (command == CMD_TICK) ?
                        32'(cfg.rate_per_ms) * 32'(elapsed_ms) : 32'd0;
        end
    end

    // Clamp the step at one full turn
    assign step  = (raw_reg > FullWide) ? FullStep : raw_reg[CHANNEL_BITS:0];
    assign entry = {kind_reg, hue_reg, sat_reg, val_reg, step};

endmodule

>>> rtl/hfrpd_queue.sv
// ----------------------------------------------------------------------------
// HSV fade driver command queue
// Short FIFO between the front end and the sequencer.
// ----------------------------------------------------------------------------
`include "hsv_fade_rgb_pwm_driver_unit_defines.svh"

module hfrpd_queue
    import hfrpd_pkg::*;
#(
    parameter int W     = 4 * CHANNEL_BITS_DEF + 2,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         not_empty
);

    localparam int PtrBits   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountBits = $clog2(DEPTH + 1);
    localparam logic [PtrBits-1:0]   LastPtr   = PtrBits'(DEPTH - 1);
    localparam logic [CountBits-1:0] DepthCnt  = CountBits'(DEPTH);

    logic [W-1:0]         mem [DEPTH];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [CountBits-1:0] count_reg;

    assign full      = (count_reg == DepthCnt);
    assign not_empty = (count_reg != '0);
    assign rdata     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `HFRPD_ASSERT_NEXT(a_count_tracks_push, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count missed a transfer in")

endmodule

>>> rtl/hfrpd_back.sv
// ----------------------------------------------------------------------------
// HSV fade driver sequencer
// Runs the fade step, then the HSV-to-RGB conversion and gamma on one shared multiplier.
// ----------------------------------------------------------------------------
`include "hsv_fade_rgb_pwm_driver_unit_defines.svh"

module hfrpd_back
    import hfrpd_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int DUTY_BITS    = DUTY_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      q_valid,
    input  logic [4*CHANNEL_BITS+1:0] q_entry,
    output logic                      pop,
    output logic                      duty_valid,
    input  logic                      duty_stall,
    output logic [DUTY_BITS-1:0]      red,
    output logic [DUTY_BITS-1:0]      green,
    output logic [DUTY_BITS-1:0]      blue,
    output logic                      settled
);

    localparam int CB = CHANNEL_BITS;
    localparam int DB = DUTY_BITS;

    localparam logic [CB:0]          Full     = {1'b1, {CB{1'b0}}};
    localparam logic signed [CB+1:0] FullTurn = {2'b01, {CB{1'b0}}};
    localparam logic signed [CB+1:0] HalfTurn = {3'b001, {(CB-1){1'b0}}};

    localparam logic [2:0] OP_SF     = 3'd0;
    localparam logic [2:0] OP_SG     = 3'd1;
    localparam logic [2:0] OP_P      = 3'd2;
    localparam logic [2:0] OP_Q      = 3'd3;
    localparam logic [2:0] OP_T      = 3'd4;
    localparam logic [2:0] GAM_LAST  = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ERR  = 8'b0000_0010,
        ST_MOVE = 8'b0000_0100,
        ST_SECT = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_SEL  = 8'b0010_0000,
        ST_GAM  = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

    state_t          state_reg;
    logic [2:0]      op_reg;
    logic            reached_reg;
    logic            duty_valid_reg;
    logic [CB-1:0]   goal_hue_reg, goal_sat_reg, goal_val_reg;
    logic [CB-1:0]   now_hue_reg, now_sat_reg, now_val_reg;

    logic [CB:0]     step_reg;
    logic [CB-1:0]   mag_h_reg, mag_s_reg, mag_v_reg;
    logic            pos_h_reg, pos_s_reg, pos_v_reg;
    logic            settled_flag_reg;
    logic [2:0]      sector_reg;
    logic [CB-1:0]   frac_reg;
    logic [CB-1:0]   sf_reg, sg_reg, p_reg, q_reg, t_reg;
    logic [CB-1:0]   r_reg, g_reg, b_reg, sq_reg;
    logic [DB-1:0]   red_reg, green_reg, blue_reg;
    logic            settled_reg;

    logic            q_kind;
    logic [CB-1:0]   q_hue, q_sat, q_val;
    logic [CB:0]     q_step;

    logic signed [CB+1:0] dh_raw, dh, ds, dv;
    logic [CB-1:0]   mag_h, mag_s, mag_v;
    logic [CB-1:0]   mx_hs, mx;
    logic            settle_now;
    logic [CB+2:0]   h6;
    logic [CB-1:0]   mul_a;
    logic [CB:0]     mul_b;
    logic [2*CB:0]   mul_p;
    logic [CB-1:0]   mul_hi;
    logic [CB-1:0]   gam_ch;
    logic            emit;

    assign q_kind = q_entry[4*CB+1];
    assign q_hue  = q_entry[4*CB:3*CB+1];
    assign q_sat  = q_entry[3*CB:2*CB+1];
    assign q_val  = q_entry[2*CB:CB+1];
    assign q_step = q_entry[CB:0];

    assign pop  = (state_reg == ST_IDLE) && q_valid;
    assign emit = (state_reg == ST_EMIT) && (!duty_valid_reg || !duty_stall);

    // Move toward the goal by step, or land on it, and wrap into one turn
    function automatic logic [CB-1:0] approach(
        input logic [CB-1:0] now,
        input logic [CB-1:0] goal,
        input logic [CB-1:0] mag,
        input logic          pos,
        input logic [CB:0]   step
    );
        logic signed [CB+1:0] nxt;
        begin
            if ({1'b0, mag} < step)
            begin
                return goal;
            end
            nxt = pos ? $signed({2'b00, now}) + $signed({1'b0, step})
                      : $signed({2'b00, now}) - $signed({1'b0, step});
            if (nxt < 0)
            begin
                nxt = nxt + FullTurn;
            end
            else if (nxt >= FullTurn)
            begin
                nxt = nxt - FullTurn;
            end
            return nxt[CB-1:0];
        end
    endfunction

    // c * (2^DB - 1) >> CB
    function automatic logic [DB-1:0] quantize(input logic [CB-1:0] c);
        logic [CB+DB-1:0] w;
        begin
            w = {c, {DB{1'b0}}} - (CB+DB)'(c);
            return w[CB+DB-1:CB];
        end
    endfunction

    // Errors; hue takes the short way round
    always_comb
    begin
        dh_raw = $signed({2'b00, goal_hue_reg}) - $signed({2'b00, now_hue_reg});
        if (dh_raw > HalfTurn)
        begin
            dh = dh_raw - FullTurn;
        end
        else if (dh_raw < -HalfTurn)
        begin
            dh = dh_raw + FullTurn;
        end
        else
        begin
            dh = dh_raw;
        end
        ds = $signed({2'b00, goal_sat_reg}) - $signed({2'b00, now_sat_reg});
        dv = $signed({2'b00, goal_val_reg}) - $signed({2'b00, now_val_reg});
        mag_h = dh[CB+1] ? CB'(-dh) : CB'(dh);
        mag_s = ds[CB+1] ? CB'(-ds) : CB'(ds);
        mag_v = dv[CB+1] ? CB'(-dv) : CB'(dv);
    end

    always_comb
    begin
        mx_hs      = (mag_h_reg > mag_s_reg) ? mag_h_reg : mag_s_reg;
        mx         = (mx_hs > mag_v_reg) ? mx_hs : mag_v_reg;
        settle_now = 32'(mx) < 32'(cfg.settle_threshold);
        h6         = ({3'b000, now_hue_reg} << 2) + ({3'b000, now_hue_reg} << 1);
    end

    always_comb
    begin
        case (op_reg[2:1])
            CH_RED:   gam_ch = r_reg;
            CH_GREEN: gam_ch = g_reg;
            default:  gam_ch = b_reg;
        endcase
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                case (op_reg)
                    OP_SF:
                    begin
                        mul_a = now_sat_reg;
                        mul_b = {1'b0, frac_reg};
                    end
                    OP_SG:
                    begin
                        mul_a = now_sat_reg;
                        mul_b = Full - {1'b0, frac_reg};
                    end
                    OP_P:
                    begin
                        mul_a = now_val_reg;
                        mul_b = Full - {1'b0, now_sat_reg};
                    end
                    OP_Q:
                    begin
                        mul_a = now_val_reg;
                        mul_b = Full - {1'b0, sf_reg};
                    end
                    default:
                    begin
                        mul_a = now_val_reg;
                        mul_b = Full - {1'b0, sg_reg};
                    end
                endcase
            end
            ST_GAM:
            begin
                mul_a = op_reg[0] ? sq_reg : gam_ch;
                mul_b = {1'b0, gam_ch};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign mul_hi = mul_p[2*CB-1:CB];

    // Control and colour state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= '0;
            reached_reg    <= 1'b0;
            duty_valid_reg <= 1'b0;
            goal_hue_reg   <= '0;
            goal_sat_reg   <= '0;
            goal_val_reg   <= '0;
            now_hue_reg    <= '0;
            now_sat_reg    <= '0;
            now_val_reg    <= '0;
        end
        else
        begin
            if (emit)
            begin
                duty_valid_reg <= 1'b1;
            end
            else if (duty_valid_reg && !duty_stall)
            begin
                duty_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (q_kind == CMD_LOAD)
                        begin
                            goal_hue_reg <= q_hue;
                            goal_sat_reg <= q_sat;
                            goal_val_reg <= q_val;
                            reached_reg  <= 1'b0;
                        end
                        else if (!reached_reg)
                        begin
                            state_reg <= ST_ERR;
                        end
                    end
                end
                ST_ERR:
                begin
                    state_reg <= ST_MOVE;
                end
                ST_MOVE:
                begin
                    if (settle_now)
                    begin
                        now_hue_reg <= goal_hue_reg;
                        now_sat_reg <= goal_sat_reg;
                        now_val_reg <= goal_val_reg;
                        reached_reg <= 1'b1;
                    end
                    else
                    begin
                        now_hue_reg <= approach(now_hue_reg, goal_hue_reg, mag_h_reg,
                                                pos_h_reg, step_reg);
                        now_sat_reg <= approach(now_sat_reg, goal_sat_reg, mag_s_reg,
                                                pos_s_reg, step_reg);
                        now_val_reg <= approach(now_val_reg, goal_val_reg, mag_v_reg,
                                                pos_v_reg, step_reg);
                    end
                    state_reg <= ST_SECT;
                end
                ST_SECT:
                begin
                    op_reg    <= OP_SF;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (op_reg == OP_T)
                    begin
                        op_reg    <= '0;
                        state_reg <= ST_SEL;
                    end
                    else
                    begin
                        op_reg <= op_reg + 3'd1;
                    end
                end
                ST_SEL:
                begin
                    op_reg    <= '0;
                    state_reg <= cfg.gamma_enable ? ST_GAM : ST_EMIT;
                end
                ST_GAM:
                begin
                    if (op_reg == GAM_LAST)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        op_reg <= op_reg + 3'd1;
                    end
                end
                ST_EMIT:
                begin
                    if (emit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            step_reg <= q_step;
        end
        if (state_reg == ST_ERR)
        begin
            mag_h_reg <= mag_h;
            mag_s_reg <= mag_s;
            mag_v_reg <= mag_v;
            pos_h_reg <= !dh[CB+1] && (dh != '0);
            pos_s_reg <= !ds[CB+1] && (ds != '0);
            pos_v_reg <= !dv[CB+1] && (dv != '0);
        end
        if (state_reg == ST_MOVE)
        begin
            settled_flag_reg <= settle_now;
        end
        if (state_reg == ST_SECT)
        begin
            sector_reg <= h6[CB+2:CB];
            frac_reg   <= h6[CB-1:0];
        end
        if (state_reg == ST_MUL)
        begin
            case (op_reg)
                OP_SF:   sf_reg <= mul_hi;
                OP_SG:   sg_reg <= mul_hi;
                OP_P:    p_reg  <= mul_hi;
                OP_Q:    q_reg  <= mul_hi;
                default: t_reg  <= mul_hi;
            endcase
        end
        if (state_reg == ST_SEL)
        begin
            case (sector_reg)
                SEC_RED_YEL:
                begin
                    r_reg <= now_val_reg;
                    g_reg <= t_reg;
                    b_reg <= p_reg;
                end
                SEC_YEL_GRN:
                begin
                    r_reg <= q_reg;
                    g_reg <= now_val_reg;
                    b_reg <= p_reg;
                end
                SEC_GRN_CYN:
                begin
                    r_reg <= p_reg;
                    g_reg <= now_val_reg;
                    b_reg <= t_reg;
                end
                SEC_CYN_BLU:
                begin
                    r_reg <= p_reg;
                    g_reg <= q_reg;
                    b_reg <= now_val_reg;
                end
                SEC_BLU_MAG:
                begin
                    r_reg <= t_reg;
                    g_reg <= p_reg;
                    b_reg <= now_val_reg;
                end
                default:
                begin
                    r_reg <= now_val_reg;
                    g_reg <= p_reg;
                    b_reg <= q_reg;
                end
            endcase
        end
        if (state_reg == ST_GAM)
        begin
            // Even steps square, odd steps multiply back in for the cube
            if (!op_reg[0])
            begin
                sq_reg <= mul_hi;
            end
            else
            begin
                case (op_reg[2:1])
                    CH_RED:   r_reg <= mul_hi;
                    CH_GREEN: g_reg <= mul_hi;
                    default:  b_reg <= mul_hi;
                endcase
            end
        end
        if (emit)
        begin
            red_reg     <= quantize(r_reg);
            green_reg   <= quantize(g_reg);
            blue_reg    <= quantize(b_reg);
            settled_reg <= settled_flag_reg;
        end
    end

    assign duty_valid = duty_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign settled    = settled_reg;

    `HFRPD_ASSERT_NEXT(a_now_only_in_move, state_reg != ST_MOVE, $stable(now_hue_reg) && $stable(now_sat_reg) && $stable(now_val_reg), "current colour changed outside the move step")
    `HFRPD_ASSERT_SAME(a_settle_sets_reached, state_reg == ST_EMIT && settled_flag_reg, reached_reg, "settled result without reached flag")
    `HFRPD_ASSERT_NEXT(a_linear_skips_gamma, state_reg == ST_SEL && !cfg.gamma_enable, state_reg == ST_EMIT, "gamma pass entered while disabled")

endmodule

>>> rtl/hsv_fade_rgb_pwm_driver_unit.sv
// Path: a tick passes the front stage register and the queue, then the error, move,
// sector, multiply, select, gamma (gamma on) and emit states; a load becomes the goal
// as the idle sequencer pops it. Throughput: one load per cycle while the sequencer is
// not busy on a tick. Reset: asynchronous, active low; colour state, valid and reached
// flags clear, registers take defaults; the duty outputs and settled are not reset.
// ----------------------------------------------------------------------------
// HSV fade driver top level
// APB register file, command front end, queue and fade/convert sequencer.
// ----------------------------------------------------------------------------
module hsv_fade_rgb_pwm_driver_unit
    import hfrpd_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int DUTY_BITS    = DUTY_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic                     command,
    input  logic [FIELD_BITS-1:0]    hue,
    input  logic [FIELD_BITS-1:0]    saturation,
    input  logic [FIELD_BITS-1:0]    brightness,
    input  logic [FIELD_BITS-1:0]    elapsed_ms,
    output logic                     duty_valid,
    input  logic                     duty_stall,
    output logic [DUTY_BITS-1:0]     red,
    output logic [DUTY_BITS-1:0]     green,
    output logic [DUTY_BITS-1:0]     blue,
    output logic                     settled
);

    localparam int EntryBits = 4 * CHANNEL_BITS + 2;

    cfg_t                 cfg_reg;
    logic [1:0]           reg_index;
    logic                 reg_write;
    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 q_valid;
    logic [EntryBits-1:0] entry;
    logic [EntryBits-1:0] q_entry;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign reg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_threshold <= SETTLE_RESET;
            cfg_reg.rate_per_ms      <= RATE_RESET;
            cfg_reg.gamma_enable     <= GAMMA_RESET;
        end
        else if (reg_write)
        begin
            case (reg_index)
                REG_SETTLE: cfg_reg.settle_threshold <= pwdata[FIELD_BITS-1:0];
                REG_RATE:   cfg_reg.rate_per_ms      <= pwdata[FIELD_BITS-1:0];
                REG_GAMMA:  cfg_reg.gamma_enable     <= pwdata[0];
                default:    cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_SETTLE: prdata = APB_DATA_BITS'(cfg_reg.settle_threshold);
            REG_RATE:   prdata = APB_DATA_BITS'(cfg_reg.rate_per_ms);
            REG_GAMMA:  prdata = APB_DATA_BITS'(cfg_reg.gamma_enable);
            default:    prdata = '0;
        endcase
    end

    hfrpd_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .elapsed_ms (elapsed_ms),
        .push       (push),
        .entry      (entry),
        .full       (full)
    );

    hfrpd_queue #(
        .W     (EntryBits),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (entry),
        .full      (full),
        .pop       (pop),
        .rdata     (q_entry),
        .not_empty (q_valid)
    );

    hfrpd_back #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .DUTY_BITS    (DUTY_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop),
        .duty_valid (duty_valid),
        .duty_stall (duty_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .settled    (settled)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV fade driver testbench
// Feeds target loads and time ticks with random gaps on both channels,
// tracks the fade and the HSV-to-duty conversion alongside the block, and
// checks every duty transfer in order across several register settings.
// ----------------------------------------------------------------------------
module tb;
    import hfrpd_pkg::*;

    localparam int     CLK_HALF    = 6;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     HOLD_OFF    = 30;
    localparam int     PHASE_ITEMS = 230;
    localparam longint CH_FULL     = longint'(1) << CHANNEL_BITS_DEF;
    localparam longint CH_HALF     = CH_FULL / 2;
    localparam longint DUTY_MAX    = (longint'(1) << DUTY_BITS_DEF) - 1;

    typedef logic [63:0] wide_t;

    typedef struct packed {
        logic [DUTY_BITS_DEF-1:0] red;
        logic [DUTY_BITS_DEF-1:0] green;
        logic [DUTY_BITS_DEF-1:0] blue;
        logic                     settled;
    } duty_t;

    class fade_tracker;
        longint settle_thr;
        longint rate;
        bit     gamma_on;
        longint goal_h, goal_s, goal_v;
        longint now_h, now_s, now_v;
        bit     reached;
        duty_t  pending_duty[$];
        int     mismatches;

        function new();
            settle_thr = SETTLE_RESET;
            rate       = RATE_RESET;
            gamma_on   = GAMMA_RESET;
            goal_h     = 0;
            goal_s     = 0;
            goal_v     = 0;
            now_h      = 0;
            now_s      = 0;
            now_v      = 0;
            reached    = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [APB_DATA_BITS-1:0] value);
            case (idx)
                REG_SETTLE: settle_thr = value[FIELD_BITS-1:0];
                REG_RATE:   rate = value[FIELD_BITS-1:0];
                REG_GAMMA:  gamma_on = value[0];
                default: ;
            endcase
        endfunction

        function longint mag(longint x);
            return (x < 0) ? -x : x;
        endfunction

        function longint approach(longint cur, longint goal, longint err, longint step);
            if (mag(err) < step)
                return goal;
            return (err > 0) ? cur + step : cur - step;
        endfunction

        function wide_t qmul(wide_t a, wide_t b);
            return (a * b) >> CHANNEL_BITS_DEF;
        endfunction

        function logic [DUTY_BITS_DEF-1:0] to_duty(wide_t c);
            wide_t lin;
            wide_t scaled;
            lin = gamma_on ? qmul(qmul(c, c), c) : c;
            scaled = (lin * DUTY_MAX) >> CHANNEL_BITS_DEF;
            return scaled[DUTY_BITS_DEF-1:0];
        endfunction

        function duty_t colour_to_duty(bit snapped);
            wide_t h, s, v, h6, sector, f, p, q, t, r, g, b;
            duty_t d;
            h = now_h;
            s = now_s;
            v = now_v;
            h6 = h * 6;
            sector = h6 >> CHANNEL_BITS_DEF;
            f = h6 & (CH_FULL - 1);
            p = qmul(v, CH_FULL - s);
            q = qmul(v, CH_FULL - qmul(s, f));
            t = qmul(v, CH_FULL - qmul(s, CH_FULL - f));
            case (sector[2:0])
                SEC_RED_YEL: begin r = v; g = t; b = p; end
                SEC_YEL_GRN: begin r = q; g = v; b = p; end
                SEC_GRN_CYN: begin r = p; g = v; b = t; end
                SEC_CYN_BLU: begin r = p; g = q; b = v; end
                SEC_BLU_MAG: begin r = t; g = p; b = v; end
                default:     begin r = v; g = p; b = q; end
            endcase
            d.red     = to_duty(r);
            d.green   = to_duty(g);
            d.blue    = to_duty(b);
            d.settled = snapped;
            return d;
        endfunction

        // Returns 1 when the command does real work (a load or a live tick).
        function bit apply_command(logic cmd, logic [FIELD_BITS-1:0] h,
                                   logic [FIELD_BITS-1:0] s, logic [FIELD_BITS-1:0] v,
                                   logic [FIELD_BITS-1:0] ms);
            longint eh, es, ev, worst, step;
            if (cmd == CMD_LOAD)
            begin
                goal_h  = h;
                goal_s  = s;
                goal_v  = v;
                reached = 1'b0;
                return 1'b1;
            end
            if (reached)
                return 1'b0;
            // take the short way round the hue circle
            eh = goal_h - now_h;
            if (eh > CH_HALF)
                eh -= CH_FULL;
            else if (eh < -CH_HALF)
                eh += CH_FULL;
            es = goal_s - now_s;
            ev = goal_v - now_v;
            worst = mag(eh);
            if (mag(es) > worst)
                worst = mag(es);
            if (mag(ev) > worst)
                worst = mag(ev);
            if (worst < settle_thr)
            begin
                now_h   = goal_h;
                now_s   = goal_s;
                now_v   = goal_v;
                reached = 1'b1;
                pending_duty.push_back(colour_to_duty(1'b1));
            end
            else
            begin
                step = rate * longint'(ms);
                if (step > CH_FULL)
                    step = CH_FULL;
                now_h = approach(now_h, goal_h, eh, step);
                if (now_h < 0)
                    now_h += CH_FULL;
                if (now_h >= CH_FULL)
                    now_h -= CH_FULL;
                now_s = approach(now_s, goal_s, es, step);
                now_v = approach(now_v, goal_v, ev, step);
                pending_duty.push_back(colour_to_duty(1'b0));
            end
            return 1'b1;
        endfunction

        function void compare_duty(duty_t got);
            duty_t want;
            if (pending_duty.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected duty transfer: r=%0d g=%0d b=%0d settled=%0b",
                             got.red, got.green, got.blue, got.settled);
                return;
            end
            want = pending_duty.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.settled !== want.settled)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("duty mismatch: expected r=%0d g=%0d b=%0d settled=%0b, got r=%0d g=%0d b=%0d settled=%0b",
                             want.red, want.green, want.blue, want.settled,
                             got.red, got.green, got.blue, got.settled);
            end
        endfunction
    endclass

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     psel       = 1'b0;
    logic                     penable    = 1'b0;
    logic                     pwrite     = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr      = '0;
    logic [APB_DATA_BITS-1:0] pwdata     = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     cmd_valid  = 1'b0;
    logic                     cmd_stall;
    logic                     command    = CMD_LOAD;
    logic [FIELD_BITS-1:0]    hue        = '0;
    logic [FIELD_BITS-1:0]    saturation = '0;
    logic [FIELD_BITS-1:0]    brightness = '0;
    logic [FIELD_BITS-1:0]    elapsed_ms = '0;
    logic                     duty_valid;
    logic                     duty_stall = 1'b0;
    logic [DUTY_BITS_DEF-1:0] red;
    logic [DUTY_BITS_DEF-1:0] green;
    logic [DUTY_BITS_DEF-1:0] blue;
    logic                     settled;

    fade_tracker tracker;
    bit          calm = 1'b0;
    int          work_items = 0;
    int          cycles = 0;

    hsv_fade_rgb_pwm_driver_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .elapsed_ms (elapsed_ms),
        .duty_valid (duty_valid),
        .duty_stall (duty_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .settled    (settled)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && duty_valid && !duty_stall)
            tracker.compare_duty({red, green, blue, settled});
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [FIELD_BITS-1:0] rand16();
        return FIELD_BITS'($urandom_range(0, (1 << FIELD_BITS) - 1));
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_ms();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r < 5)
            return FIELD_BITS'($urandom_range(1, 20));
        if (r < 8)
            return FIELD_BITS'($urandom_range(0, 2000));
        return rand16();
    endfunction

    function automatic logic [FIELD_BITS-1:0] nudge(longint base);
        wide_t w;
        w = base + $urandom_range(0, 800) - 400;
        return w[FIELD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] extreme_value();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return 16'h8000;
        endcase
    endfunction

    // Receiver side: random stall bursts, none started while calm.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            duty_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    task automatic send_command(input logic cmd, input logic [FIELD_BITS-1:0] h,
                                input logic [FIELD_BITS-1:0] s,
                                input logic [FIELD_BITS-1:0] v,
                                input logic [FIELD_BITS-1:0] ms);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid  <= 1'b1;
        command    <= cmd;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        elapsed_ms <= ms;
        // hold the payload until the transfer goes through
        do @(posedge clk); while (cmd_stall);
        void'(tracker.apply_command(cmd, h, s, v, ms));
        work_items++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        cmd_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending_duty.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic fade_sequence();
        int                    kind;
        logic [FIELD_BITS-1:0] th, ts, tv;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            th = rand16();
            ts = rand16();
            tv = rand16();
        end
        else if (kind < 8)
        begin
            // small errors around the current colour exercise the settle compare
            th = nudge(tracker.now_h);
            ts = nudge(tracker.now_s);
            tv = nudge(tracker.now_v);
        end
        else if (kind == 8)
        begin
            th = extreme_value();
            ts = extreme_value();
            tv = extreme_value();
        end
        else
        begin
            th = FIELD_BITS'(tracker.now_h);
            ts = FIELD_BITS'(tracker.now_s);
            tv = FIELD_BITS'(tracker.now_v);
        end
        send_command(CMD_LOAD, th, ts, tv, rand16());
        if ($urandom_range(0, 9) == 0)
            send_command(CMD_LOAD, rand16(), rand16(), rand16(), rand16());
        repeat ($urandom_range(1, 12))
            send_command(CMD_TICK, rand16(), rand16(), rand16(), pick_ms());
        if ($urandom_range(0, 9) == 0)
            send_command(1'($urandom_range(0, 1)), rand16(), rand16(), rand16(), rand16());
    endtask

    task automatic run_phase(input logic [APB_DATA_BITS-1:0] thr,
                             input logic [APB_DATA_BITS-1:0] rate,
                             input logic [APB_DATA_BITS-1:0] gam, input bit quiet);
        drop_valid();
        wait_drained();
        // a trailing load may still be in flight
        repeat (HOLD_OFF) @(posedge clk);
        write_reg(REG_SETTLE, thr);
        write_reg(REG_RATE, rate);
        write_reg(REG_GAMMA, gam);
        calm = quiet;
        work_items = 0;
        while (work_items < PHASE_ITEMS)
            fade_sequence();
    endtask

    task automatic directed_checks();
        // settle straight out of reset, then an ignored tick
        send_command(CMD_TICK, '0, '0, '0, 16'd5);
        send_command(CMD_TICK, '1, '1, '1, 16'd5);
        // hue error of exactly half a turn, zero step, small step, full-scale step
        send_command(CMD_LOAD, 16'h8000, '1, '1, '0);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), '0);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), 16'd10);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), '1);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), 16'd1);
        // hue error of minus half a turn
        send_command(CMD_LOAD, '0, '0, '1, '0);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), '1);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), 16'd1);
        // hue steps below zero and wraps to the top
        send_command(CMD_LOAD, 16'hF000, 16'h8000, 16'h8000, '0);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), 16'd10);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), '1);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), 16'd1);
        // hue steps past full turn and wraps to the bottom
        send_command(CMD_LOAD, 16'h0100, '1, '0, '0);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), 16'd64);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), '1);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), '0);
        // back-to-back loads, only the last one counts
        send_command(CMD_LOAD, '1, '1, '1, '1);
        send_command(CMD_LOAD, 16'h2AAA, '1, '1, '0);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), '1);
        send_command(CMD_TICK, rand16(), rand16(), rand16(), '0);
    endtask

    initial
    begin
        tracker = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed_checks();
        run_phase(0, 65535, 0, 1'b0);
        run_phase(65535, 0, 1, 1'b0);
        run_phase(1000, 300, 0, 1'b1);
        run_phase($urandom_range(0, 65535), $urandom_range(0, 4000),
                  $urandom_range(0, 1), 1'b0);
        run_phase(SETTLE_RESET, RATE_RESET, GAMMA_RESET, 1'b0);
        run_phase(50, 1, 1, 1'b0);
        drop_valid();
        wait_drained();
        repeat (HOLD_OFF) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_duty.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
